// ----- hdl/dgas_pkg.sv -----
// ----------------------------------------------------------------------------
// dgas_pkg
// Shared types and constants for the directed graph adjacency store.
// ----------------------------------------------------------------------------
package dgas_pkg;

	localparam int ID_W        = 32;
	localparam int COUNT_W     = 7;
	localparam int QUEUE_DEPTH = 2;

	// Request codes, in the encoding of the req_type port.
	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUCC = 2'd1,
		OP_PRED = 2'd2,
		OP_ALL  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  a;
		logic [ID_W-1:0]  b;
		logic             self_loop;
	} item_t;

	// One result item.
	typedef struct packed {
		logic               vld;
		logic [ID_W-1:0]    vertex;
		logic               has;
		logic               last;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} res_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_LOOKUP,
		BS_ADD_RD,
		BS_ADD_WA,
		BS_ADD_WB,
		BS_ADD_DONE,
		BS_LIST,
		BS_LIST_END
	} back_state_t;

endpackage

// ----- hdl/dgas_ram.sv -----
// ----------------------------------------------------------------------------
// dgas_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dgas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/dgas_fifo.sv -----
// ----------------------------------------------------------------------------
// dgas_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dgas_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dgas_pkg::item_t      push_item,
	input  logic                 pop,
	output dgas_pkg::item_t      head,
	output dgas_pkg::queue_stat_t stat
);

	localparam int PW = (dgas_pkg::QUEUE_DEPTH > 1) ? $clog2(dgas_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(dgas_pkg::QUEUE_DEPTH + 1);

	dgas_pkg::item_t entry_q [dgas_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (p == PW'(dgas_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (fill_q == CW'(dgas_pkg::QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);

endmodule

// ----- hdl/dgas_front.sv -----
// ----------------------------------------------------------------------------
// dgas_front
// Accepts requests while the queue has room and classifies them.
// ----------------------------------------------------------------------------
module dgas_front (
	input  logic                  start,
	input  logic [1:0]            req_type,
	input  logic [31:0]           vertex_a,
	input  logic [31:0]           vertex_b,
	input  dgas_pkg::queue_stat_t q_stat,
	output logic                  busy,
	output logic                  push,
	output dgas_pkg::item_t       item
);

	always_comb begin
		case (req_type)
			dgas_pkg::OP_ADD:  item.op = dgas_pkg::OP_ADD;
			dgas_pkg::OP_SUCC: item.op = dgas_pkg::OP_SUCC;
			dgas_pkg::OP_PRED: item.op = dgas_pkg::OP_PRED;
			default:           item.op = dgas_pkg::OP_ALL;
		endcase
		item.a         = vertex_a;
		item.b         = vertex_b;
		// A self loop on an unknown vertex must take only one index.
		item.self_loop = (vertex_a == vertex_b);
	end

	assign busy = q_stat.full;
	assign push = start && !q_stat.full;

endmodule

// ----- hdl/dgas_back.sv -----
// ----------------------------------------------------------------------------
// dgas_back
// Executes queued items against the identifier and adjacency memories.
// ----------------------------------------------------------------------------
module dgas_back #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dgas_pkg::item_t       head,
	input  dgas_pkg::queue_stat_t q_stat,
	output logic                  pop,
	output dgas_pkg::res_t        res
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	dgas_pkg::back_state_t state_q, state_d;
	dgas_pkg::item_t       item_q;

	logic [CW-1:0]           total_q;
	logic [CW-1:0]           cnt_q;
	logic                    rd_vld_s1;
	logic [IW-1:0]           rd_idx_s1;
	logic                    found_a_q, found_b_q;
	logic [IW-1:0]           idx_a_q, idx_b_q;
	logic                    pend_vld_q;
	logic [dgas_pkg::ID_W-1:0] pend_id_q;

	logic                      ids_we;
	logic [IW-1:0]             ids_waddr;
	logic [dgas_pkg::ID_W-1:0] ids_wdata;
	logic [dgas_pkg::ID_W-1:0] ids_rdata;
	logic                      adj_we;
	logic [IW-1:0]             adj_waddr;
	logic [MAX_VERTICES-1:0]   adj_wdata;
	logic [IW-1:0]             adj_raddr;
	logic [MAX_VERTICES-1:0]   adj_rdata;

	logic           issue;
	logic           scan_done;
	logic           is_full;
	logic           hit;
	logic           new_b;
	logic [CW:0]    need_total;
	logic [CW-1:0]  total_plus;
	logic [IW-1:0]  ia_new, ib_new;
	dgas_pkg::res_t emit;

	dgas_ram #(.WIDTH(dgas_pkg::ID_W), .DEPTH(MAX_VERTICES)) u_ids (
		.clk   (clk),
		.we    (ids_we),
		.waddr (ids_waddr),
		.wdata (ids_wdata),
		.raddr (cnt_q[IW-1:0]),
		.rdata (ids_rdata)
	);

	dgas_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Scan and allocation arithmetic.
	assign issue      = ((state_q == dgas_pkg::BS_LOOKUP) || (state_q == dgas_pkg::BS_LIST))
	                    && (cnt_q < total_q);
	assign scan_done  = (cnt_q == total_q) && !rd_vld_s1;
	assign new_b      = !found_b_q && !item_q.self_loop;
	assign need_total = (CW+1)'(total_q) + (CW+1)'(!found_a_q) + (CW+1)'(new_b);
	assign is_full    = (need_total > (CW+1)'(MAX_VERTICES));
	assign total_plus = total_q + CW'(!found_a_q);
	assign ia_new     = found_a_q ? idx_a_q : IW'(total_q);
	assign ib_new     = found_b_q ? idx_b_q : (item_q.self_loop ? ia_new : IW'(total_plus));

	always_comb begin
		case (item_q.op)
			dgas_pkg::OP_SUCC: hit = adj_rdata[rd_idx_s1];
			dgas_pkg::OP_PRED: hit = adj_rdata[idx_a_q];
			default:           hit = 1'b1;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dgas_pkg::BS_IDLE: begin
				if (!q_stat.empty) begin
					state_d = (head.op == dgas_pkg::OP_ALL) ? dgas_pkg::BS_LIST
					                                        : dgas_pkg::BS_LOOKUP;
				end
			end
			dgas_pkg::BS_LOOKUP: begin
				if (scan_done) begin
					if (item_q.op == dgas_pkg::OP_ADD) begin
						state_d = is_full ? dgas_pkg::BS_IDLE : dgas_pkg::BS_ADD_RD;
					end else begin
						state_d = found_a_q ? dgas_pkg::BS_LIST : dgas_pkg::BS_IDLE;
					end
				end
			end
			dgas_pkg::BS_ADD_RD:   state_d = dgas_pkg::BS_ADD_WA;
			dgas_pkg::BS_ADD_WA:   state_d = new_b ? dgas_pkg::BS_ADD_WB : dgas_pkg::BS_ADD_DONE;
			dgas_pkg::BS_ADD_WB:   state_d = dgas_pkg::BS_ADD_DONE;
			dgas_pkg::BS_ADD_DONE: state_d = dgas_pkg::BS_IDLE;
			dgas_pkg::BS_LIST: begin
				if (scan_done) begin
					state_d = dgas_pkg::BS_LIST_END;
				end
			end
			dgas_pkg::BS_LIST_END: state_d = dgas_pkg::BS_IDLE;
			default:               state_d = dgas_pkg::BS_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop       = 1'b0;
		ids_we    = 1'b0;
		ids_waddr = idx_a_q;
		ids_wdata = item_q.a;
		adj_we    = 1'b0;
		adj_waddr = idx_a_q;
		adj_wdata = '0;
		adj_raddr = cnt_q[IW-1:0];
		emit        = '0;
		emit.count  = dgas_pkg::COUNT_W'(total_q);
		emit.status = dgas_pkg::ST_OK;
		case (state_q)
			dgas_pkg::BS_IDLE: begin
				pop = !q_stat.empty;
			end
			dgas_pkg::BS_LOOKUP: begin
				if (scan_done) begin
					if (item_q.op == dgas_pkg::OP_ADD) begin
						if (is_full) begin
							emit.vld    = 1'b1;
							emit.last   = 1'b1;
							emit.status = dgas_pkg::ST_FULL;
						end
					end else if (!found_a_q) begin
						emit.vld    = 1'b1;
						emit.last   = 1'b1;
						emit.status = dgas_pkg::ST_UNKNOWN;
					end
				end
			end
			dgas_pkg::BS_ADD_RD: begin
				adj_raddr = idx_a_q;
			end
			dgas_pkg::BS_ADD_WA: begin
				ids_we    = !found_a_q;
				ids_waddr = idx_a_q;
				ids_wdata = item_q.a;
				adj_we    = 1'b1;
				adj_waddr = idx_a_q;
				adj_wdata = (found_a_q ? adj_rdata : '0)
				            | (MAX_VERTICES'(1) << idx_b_q);
			end
			dgas_pkg::BS_ADD_WB: begin
				ids_we    = 1'b1;
				ids_waddr = idx_b_q;
				ids_wdata = item_q.b;
				adj_we    = 1'b1;
				adj_waddr = idx_b_q;
				adj_wdata = '0;
			end
			dgas_pkg::BS_ADD_DONE: begin
				emit.vld  = 1'b1;
				emit.last = 1'b1;
			end
			dgas_pkg::BS_LIST: begin
				if (item_q.op == dgas_pkg::OP_SUCC) begin
					adj_raddr = idx_a_q;
				end
				if (rd_vld_s1 && hit && pend_vld_q) begin
					emit.vld    = 1'b1;
					emit.vertex = pend_id_q;
					emit.has    = 1'b1;
				end
			end
			dgas_pkg::BS_LIST_END: begin
				emit.vld    = 1'b1;
				emit.last   = 1'b1;
				emit.has    = pend_vld_q;
				emit.vertex = pend_vld_q ? pend_id_q : '0;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == dgas_pkg::BS_LIST && rd_vld_s1 && hit) begin
			pend_id_q <= ids_rdata;
		end
		rd_idx_s1 <= cnt_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dgas_pkg::BS_IDLE;
			total_q    <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			found_a_q  <= 1'b0;
			found_b_q  <= 1'b0;
			idx_a_q    <= '0;
			idx_b_q    <= '0;
			pend_vld_q <= 1'b0;
			res        <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			res       <= emit;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				dgas_pkg::BS_IDLE: begin
					cnt_q      <= '0;
					found_a_q  <= 1'b0;
					found_b_q  <= 1'b0;
					pend_vld_q <= 1'b0;
				end
				dgas_pkg::BS_LOOKUP: begin
					if (rd_vld_s1 && ids_rdata == item_q.a) begin
						found_a_q <= 1'b1;
						idx_a_q   <= rd_idx_s1;
					end
					if (rd_vld_s1 && ids_rdata == item_q.b) begin
						found_b_q <= 1'b1;
						idx_b_q   <= rd_idx_s1;
					end
					// The listing pass scans again from index zero.
					if (scan_done) begin
						cnt_q <= '0;
					end
				end
				dgas_pkg::BS_ADD_RD: begin
					idx_a_q <= ia_new;
					idx_b_q <= ib_new;
				end
				dgas_pkg::BS_ADD_WA: begin
					total_q <= total_plus;
				end
				dgas_pkg::BS_ADD_WB: begin
					total_q <= total_q + CW'(1);
				end
				dgas_pkg::BS_LIST: begin
					if (rd_vld_s1 && hit) begin
						pend_vld_q <= 1'b1;
					end
				end
				default: begin
					pend_vld_q <= pend_vld_q;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_VERTICES))
		else $error("vertex total beyond table size");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(rd_idx_s1) < total_q))
		else $error("scan read beyond allocated vertices");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.vld && emit.last) |=> (state_q == dgas_pkg::BS_IDLE))
		else $error("item did not finish after its last result");

	a_vertex_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.vld && emit.has) |-> (emit.status == dgas_pkg::ST_OK && !pop))
		else $error("listed vertex with error status");
`endif

endmodule

// ----- hdl/directed_graph_adjacency_store.sv -----
// ----------------------------------------------------------------------------
// directed_graph_adjacency_store
// Directed graph store with dense vertex indices and an adjacency bit matrix.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Requests first land in a two-item queue, so busy rises only when that queue
// is full; the back end then works through them one at a time. Every request
// scans the identifier memory one entry per cycle, so its cost grows with the
// vertex count N. An add edge looks up both endpoints, reads the source row,
// writes it back with the new edge and, when it brings in a new destination
// vertex, writes that vertex a row too; when the table has no room it ends
// after the lookup. A list of all vertices scans once, a list of successors
// or predecessors twice: once to find the queried vertex and once to list.
// Results appear one per cycle at most, each for exactly one cycle with valid
// high; the receiver has no way to hold them off and must take every one. A
// query gives one result per listed vertex in index order with last on the
// final one, or a single result with has_vertex low when it lists nothing or
// names an unknown vertex (status 2). An add edge always gives one result,
// with status 1 when the table would overflow, in which case nothing is
// stored. Adjacency rows are written whenever a vertex gets its index, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module directed_graph_adjacency_store #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] vertex_a,
	input  logic signed [31:0] vertex_b,
	output logic               valid,
	output logic signed [31:0] vertex_out,
	output logic               has_vertex,
	output logic               last,
	output logic [6:0]         vertex_count,
	output logic [1:0]         status
);

	dgas_pkg::item_t       push_item;
	dgas_pkg::item_t       head;
	dgas_pkg::queue_stat_t q_stat;
	dgas_pkg::res_t        res;
	logic                  push;
	logic                  pop;

	// The front classifies requests and pushes them into the queue.
	dgas_front u_front (
		.start    (start),
		.req_type (req_type),
		.vertex_a (vertex_a),
		.vertex_b (vertex_b),
		.q_stat   (q_stat),
		.busy     (busy),
		.push     (push),
		.item     (push_item)
	);

	dgas_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// The back end owns both memories and the registered result.
	dgas_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.res    (res)
	);

	assign valid        = res.vld;
	assign vertex_out   = res.vertex;
	assign has_vertex   = res.has;
	assign last         = res.last;
	assign vertex_count = res.count;
	assign status       = res.status;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the directed graph adjacency store. A directed
// table comes first, then random requests shaped to grow the graph, fill the
// vertex table to its edge and keep working once it is full. Every result is
// checked field by field against a typed table answer or a predictor that
// keeps its own copy of the vertex table and the adjacency bit matrix.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRAPH_SIZE = 64;

	// One expected result item, in the order of the result ports.
	typedef struct packed {
		logic [31:0]       vertex;
		logic              has;
		logic              last;
		logic [6:0]        count;
		dgas_pkg::status_t status;
	} graph_result_t;

	// One row of the directed table. Rows with a typed answer give exactly one
	// result whose value can be read off at a glance; the other rows take
	// their answers from the predictor.
	typedef struct {
		dgas_pkg::op_t op;
		logic [31:0]   a;
		logic [31:0]   b;
		bit            typed;
		graph_result_t answer;
	} graph_step_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic signed [31:0] vertex_a;
	logic signed [31:0] vertex_b;
	logic               valid;
	logic signed [31:0] vertex_out;
	logic               has_vertex;
	logic               last;
	logic [6:0]         vertex_count;
	logic [1:0]         status;

	// Predictor state: identifier per dense index, the number of known
	// vertices, and one row of outgoing edges per source index.
	logic [31:0]           known_ids [GRAPH_SIZE];
	int                    known_count;
	logic [GRAPH_SIZE-1:0] out_edges [GRAPH_SIZE];

	// Results still owed by the block, oldest first.
	graph_result_t pending_answers[$];
	int            error_count = 0;

	// Sender burst bookkeeping.
	int burst_left = 0;

	graph_step_t directed_steps[20];

	directed_graph_adjacency_store #(
		.MAX_VERTICES(GRAPH_SIZE)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.valid       (valid),
		.vertex_out  (vertex_out),
		.has_vertex  (has_vertex),
		.last        (last),
		.vertex_count(vertex_count),
		.status      (status)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Dense index of an identifier, or -1 when the identifier is not known.
	function automatic int index_of(input logic [31:0] id);
		for (int i = 0; i < known_count; i++) begin
			if (known_ids[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Appends one expectation to the end of the owed results.
	function automatic void owe_answer(input graph_result_t r);
		pending_answers = {pending_answers, r};
	endfunction

	function automatic void push_answer(input bit record, input logic [31:0] vertex,
		input logic has, input logic fin, input dgas_pkg::status_t st);
		graph_result_t r;
		r.vertex = vertex;
		r.has    = has;
		r.last   = fin;
		r.count  = known_count[6:0];
		r.status = st;
		if (record)
			owe_answer(r);
	endfunction

	// Updates the graph for one accepted item and, when record is set, queues
	// the results it should cause. Typed table rows still pass through here so
	// that the graph state stays in step with the block.
	function automatic void answer_request(input dgas_pkg::op_t op, input logic [31:0] a,
		input logic [31:0] b, input bit record);
		int ia;
		int ib;
		int q;
		int need;
		int hits;
		int n;
		bit hit;
		if (op == dgas_pkg::OP_ADD) begin
			ia   = index_of(a);
			ib   = index_of(b);
			need = 0;
			if (ia < 0)
				need++;
			if (ib < 0 && b != a)
				need++;
			// Nothing is stored unless every new endpoint fits.
			if (known_count + need > GRAPH_SIZE) begin
				push_answer(record, '0, 1'b0, 1'b1, dgas_pkg::ST_FULL);
				return;
			end
			if (ia < 0) begin
				ia = known_count;
				known_ids[known_count] = a;
				known_count++;
			end
			if (ib < 0) begin
				// A self loop on a new vertex takes a single index.
				if (b == a) begin
					ib = ia;
				end else begin
					ib = known_count;
					known_ids[known_count] = b;
					known_count++;
				end
			end
			out_edges[ia][ib] = 1'b1;
			push_answer(record, '0, 1'b0, 1'b1, dgas_pkg::ST_OK);
			return;
		end

		q = -1;
		if (op != dgas_pkg::OP_ALL) begin
			q = index_of(a);
			if (q < 0) begin
				push_answer(record, '0, 1'b0, 1'b1, dgas_pkg::ST_UNKNOWN);
				return;
			end
		end

		// Two passes: the first counts the hits so that the second knows which
		// result carries the last marker.
		hits = 0;
		for (int pass = 0; pass < 2; pass++) begin
			n = 0;
			for (int i = 0; i < known_count; i++) begin
				case (op)
					dgas_pkg::OP_SUCC: hit = out_edges[q][i];
					dgas_pkg::OP_PRED: hit = out_edges[i][q];
					default:           hit = 1'b1;
				endcase
				if (hit) begin
					n++;
					if (pass == 1)
						push_answer(record, known_ids[i], 1'b1, n == hits,
							dgas_pkg::ST_OK);
				end
			end
			hits = n;
		end
		// An empty list still gives one result.
		if (hits == 0)
			push_answer(record, '0, 1'b0, 1'b1, dgas_pkg::ST_OK);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// A random identifier that the graph does not know yet.
	function automatic logic [31:0] fresh_id();
		logic [31:0] x;
		x = $urandom;
		while (index_of(x) >= 0)
			x = $urandom;
		return x;
	endfunction

	function automatic logic [31:0] pick_known();
		return known_ids[$urandom_range(0, known_count - 1)];
	endfunction

	// Mostly known vertices, so that edges pile up on a shared set and the
	// lists get long; a new one now and then while there is room.
	function automatic logic [31:0] pick_endpoint(input bit allow_fresh);
		if (known_count == 0 || (allow_fresh && $urandom_range(0, 9) < 3))
			return fresh_id();
		return pick_known();
	endfunction

	// Presents one item and waits until the block takes it. Between bursts the
	// sender drops start for a random number of cycles. Inputs change only on
	// the falling edge; acceptance is judged on the rising edge.
	task automatic send_request(input dgas_pkg::op_t op, input logic [31:0] a,
		input logic [31:0] b, input bit typed, input graph_result_t typed_answer);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			// Some bursts are long enough to keep the queue full for a while.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		@(negedge clk);
		start    <= 1'b1;
		req_type <= op;
		vertex_a <= a;
		vertex_b <= b;
		do
			@(posedge clk);
		while (busy);
		answer_request(op, a, b, !typed);
		if (typed)
			owe_answer(typed_answer);
		burst_left--;
	endtask

	task automatic send_add(input logic [31:0] a, input logic [31:0] b);
		send_request(dgas_pkg::OP_ADD, a, b, 1'b0, '0);
	endtask

	// One random item of the general mix. The add branch brings in new vertices
	// only while allow_fresh is set; noise items carry fully random identifiers.
	task automatic send_mixed(input bit allow_fresh, input int add_pct);
		int r;
		logic [31:0] a;
		logic [31:0] b;
		r = $urandom_range(0, 99);
		if (r < add_pct) begin
			a = pick_endpoint(allow_fresh);
			b = ($urandom_range(0, 9) == 0) ? a : pick_endpoint(allow_fresh);
			send_add(a, b);
		end else if (r < add_pct + 30) begin
			// Successors or predecessors, now and then of an unknown vertex.
			a = ($urandom_range(0, 9) == 0) ? fresh_id() : pick_known();
			send_request($urandom_range(0, 1) ? dgas_pkg::OP_SUCC : dgas_pkg::OP_PRED,
				a, $urandom, 1'b0, '0);
		end else if (r < add_pct + 40) begin
			send_request(dgas_pkg::OP_ALL, $urandom, $urandom, 1'b0, '0);
		end else if (allow_fresh) begin
			send_request(dgas_pkg::op_t'($urandom_range(1, 3)), $urandom, $urandom,
				1'b0, '0);
		end else begin
			// Once the table is nearly full, noise may also try to add edges.
			send_request(dgas_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom,
				1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// The receiver cannot hold results off, so every cycle with valid high is
	// one result item that has to match the oldest expectation.
	always @(posedge clk) begin
		graph_result_t want;
		if (arst_n && valid) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual vertex %h count %0d",
					$time, vertex_out, vertex_count);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				check_field("vertex_out", want.vertex, vertex_out);
				check_field("has_vertex", 32'(want.has), 32'(has_vertex));
				check_field("last", 32'(want.last), 32'(last));
				check_field("vertex_count", 32'(want.count), 32'(vertex_count));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		int steered;
		logic [31:0] a;
		logic [31:0] b;

		start       = 1'b0;
		req_type    = dgas_pkg::OP_ADD;
		vertex_a    = '0;
		vertex_b    = '0;
		arst_n      = 1'b0;
		known_count = 0;
		for (int i = 0; i < GRAPH_SIZE; i++) begin
			known_ids[i] = '0;
			out_edges[i] = '0;
		end

		// Directed table. Typed answers are one result each; the rest are left
		// to the predictor.
		directed_steps = '{
			// Empty graph: the full list is a single empty result.
			'{dgas_pkg::OP_ALL,  32'h0000_0000, 32'h0000_0000, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd0, dgas_pkg::ST_OK}},
			// Queries on an empty graph name unknown vertices.
			'{dgas_pkg::OP_SUCC, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd0, dgas_pkg::ST_UNKNOWN}},
			'{dgas_pkg::OP_PRED, 32'h8000_0000, 32'h0000_0000, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd0, dgas_pkg::ST_UNKNOWN}},
			// Extreme identifiers in both directions, then a repeated edge.
			'{dgas_pkg::OP_ADD,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd2, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_ADD,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd2, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_ADD,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd2, dgas_pkg::ST_OK}},
			// A self loop on a new vertex takes one index.
			'{dgas_pkg::OP_ADD,  32'h0000_0000, 32'h0000_0000, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd3, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_ADD,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd4, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_SUCC, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
			'{dgas_pkg::OP_PRED, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
			'{dgas_pkg::OP_SUCC, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
			'{dgas_pkg::OP_PRED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
			'{dgas_pkg::OP_SUCC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
			// Nothing points at this vertex, so the list is empty.
			'{dgas_pkg::OP_PRED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd4, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_ALL,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
			// Self loop on a vertex that is already known.
			'{dgas_pkg::OP_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd4, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_SUCC, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd4, dgas_pkg::ST_UNKNOWN}},
			'{dgas_pkg::OP_ADD,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
				'{32'h0, 1'b0, 1'b1, 7'd6, dgas_pkg::ST_OK}},
			'{dgas_pkg::OP_ALL,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
			// Queries ignore vertex_b.
			'{dgas_pkg::OP_PRED, 32'hAAAA_AAAA, 32'h1234_5678, 1'b0, '0}
		};

		// Reset is asserted once and released between edges.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[i])
			send_request(directed_steps[i].op, directed_steps[i].a, directed_steps[i].b,
				directed_steps[i].typed, directed_steps[i].answer);

		// Random growth: the graph gains vertices and edges while staying
		// clear of the table limit.
		for (int i = 0; i < 170; i++)
			send_mixed(known_count <= 60, 50);

		// Steer the vertex count up to one below the limit with random
		// identifiers, mixing pairs of new vertices, new self loops and
		// edges between a new and a known vertex.
		steered = 0;
		while (known_count < GRAPH_SIZE - 1) begin
			a = fresh_id();
			case ($urandom_range(0, 3))
				0: begin
					if (known_count <= GRAPH_SIZE - 3) begin
						b = fresh_id();
						while (b == a)
							b = fresh_id();
					end else begin
						b = a;
					end
					send_add(a, b);
				end
				1: send_add(a, a);
				2: send_add(a, pick_known());
				default: send_add(pick_known(), a);
			endcase
			if (steered % 5 == 4)
				send_request(dgas_pkg::OP_ALL, $urandom, $urandom, 1'b0, '0);
			steered++;
		end

		// One slot left: two new endpoints do not fit, a new self loop does.
		a = fresh_id();
		b = fresh_id();
		while (b == a)
			b = fresh_id();
		send_add(a, b);
		a = fresh_id();
		send_add(a, a);
		// The table is now full: any new endpoint is refused, known ones still
		// take edges.
		send_add(fresh_id(), pick_known());
		send_add(pick_known(), fresh_id());
		a = fresh_id();
		send_add(a, a);
		send_add(pick_known(), pick_known());
		send_request(dgas_pkg::OP_ALL, $urandom, $urandom, 1'b0, '0);

		// Random traffic on a full table, long lists included.
		for (int i = 0; i < 80; i++)
			send_mixed(1'b0, 35);

		@(negedge clk);
		start <= 1'b0;

		// Wait for every owed result, then long enough for a full-length list
		// to show up if the block were to emit anything extra.
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Hard limit on the run, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/dgas_pkg.sv
hdl/dgas_ram.sv
hdl/dgas_fifo.sv
hdl/dgas_front.sv
hdl/dgas_back.sv
hdl/directed_graph_adjacency_store.sv
bench/testbench.sv
